@@ hw/rtl/bbs_pkg.sv @@
// Package for the indexed Blum Blum Shub generator.
// Widths, register indexes and the modular add helper; no dependencies.
`default_nettype none

package bbs_pkg;

    localparam int PRIME_BITS = 17;
    localparam int INDEX_BITS = 32;
    localparam int SEED_BITS  = 2 * PRIME_BITS;
    localparam int CNT_BITS   = $clog2(((INDEX_BITS > SEED_BITS) ? INDEX_BITS : SEED_BITS) + 1);
    localparam int K_BITS     = $clog2(PRIME_BITS + 1);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEED   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND = 2'd2;

    typedef logic [SEED_BITS-1:0] word_t;

    // (a + b) mod m for a, b below m
    function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
        logic [SEED_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[SEED_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/blum_blum_shub_indexed_bit_top.sv @@
// Indexed Blum Blum Shub generator: x = seed^(2^i mod lambda) mod p*q.
// Uses bbs_pkg for widths, register indexes and the modular add.
//
// channel | signals                                   | direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data     | in (ready out)
// in      | in_valid in_ready seq_index                | in (ready out)
// out     | out_valid out_ready random_bit state_value | out (ready in)
//
// One item at a time. n = p*q is formed first, then the binary gcd and the
// quotient, then 2^i mod lambda takes INDEX_BITS rounds of one bit-serial
// modular square and an optional doubling; the seed is reduced bit-serially,
// and the final power takes SEED_BITS rounds of up to two bit-serial
// products. Run time is set mostly by the shared shift-and-add unit.
// Reset loads seed 3, primes 3 and 7. A waiting result holds in the output
// register; the next item is taken meanwhile and stalls only at its own finish.
`default_nettype none

module blum_blum_shub_indexed_bit_top
    import bbs_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_IDX_BITS-1:0] cfg_index,
    input  wire  [SEED_BITS-1:0]    cfg_data,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [INDEX_BITS-1:0]   seq_index,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic                    random_bit,
    output logic [SEED_BITS-1:0]    state_value
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GCD   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_LAM   = 4'd3;
    localparam logic [3:0] S_EINIT = 4'd4;
    localparam logic [3:0] S_ESQ   = 4'd5;
    localparam logic [3:0] S_EDBL  = 4'd6;
    localparam logic [3:0] S_XINIT = 4'd7;
    localparam logic [3:0] S_RED   = 4'd8;
    localparam logic [3:0] S_XSQ   = 4'd9;
    localparam logic [3:0] S_XBIT  = 4'd10;
    localparam logic [3:0] S_XNEXT = 4'd11;
    localparam logic [3:0] S_MM    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    localparam word_t ONE = word_t'(1);

    logic [SEED_BITS-1:0]  seed_reg;
    logic [PRIME_BITS-1:0] p_reg, q_reg;

    logic [3:0]            state_reg, state_next, ret_reg, ret_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [PRIME_BITS-1:0] ga_reg, ga_next, gb_reg, gb_next, g_reg, g_next, dq_reg, dq_next;
    logic [K_BITS-1:0]     k_reg, k_next;
    logic [SEED_BITS:0]    rem_reg, rem_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    word_t n_reg, n_next, mod_reg, mod_next, r_reg, r_next, base_reg, base_next;
    word_t e_reg, e_next, acc_reg, acc_next, ma_reg, ma_next, mb_reg, mb_next;
    logic                  out_valid_reg, out_valid_next;
    word_t                 out_reg, out_next;

    logic [PRIME_BITS-1:0] pm1, qm1;
    logic [PRIME_BITS:0]   div_trial;
    logic [SEED_BITS:0]    red_trial;

    assign pm1       = p_reg - 1'b1;
    assign qm1       = q_reg - 1'b1;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign state_value = out_reg;
    assign random_bit  = out_reg[0];
    assign div_trial = {rem_reg[PRIME_BITS-1:0], dq_reg[PRIME_BITS-1]};
    assign red_trial = {rem_reg[SEED_BITS-1:0], base_reg[SEED_BITS-1]};

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        idx_next   = idx_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        g_next     = g_reg;
        dq_next    = dq_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        mod_next   = mod_reg;
        r_next     = r_reg;
        base_next  = base_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        out_next   = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = seq_index;
                    n_next   = word_t'(p_reg) * word_t'(q_reg);
                    ga_next  = pm1;
                    gb_next  = qm1;
                    k_next   = '0;
                    e_next   = '0;
                    if (p_reg < 2 || q_reg < 2)
                    begin
                        state_next = S_XINIT;
                    end
                    else
                    begin
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                // binary gcd: strip common twos, then subtract odd from odd
                if (ga_reg == gb_reg)
                begin
                    g_next     = ga_reg << k_reg;
                    dq_next    = pm1;
                    rem_next   = '0;
                    cnt_next   = CNT_BITS'(PRIME_BITS);
                    state_next = S_DIV;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    k_next  = k_reg + 1'b1;
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_reg > gb_reg)
                begin
                    ga_next = ga_reg - gb_reg;
                end
                else
                begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            S_DIV:
            begin
                if (div_trial >= {1'b0, g_reg})
                begin
                    rem_next = (SEED_BITS+1)'(div_trial - {1'b0, g_reg});
                    dq_next  = {dq_reg[PRIME_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = (SEED_BITS+1)'(div_trial);
                    dq_next  = {dq_reg[PRIME_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    state_next = S_LAM;
                end
            end
            S_LAM:
            begin
                mod_next   = word_t'(dq_reg) * word_t'(qm1);
                state_next = S_EINIT;
            end
            S_EINIT:
            begin
                r_next     = (mod_reg == ONE) ? '0 : ONE;
                cnt_next   = CNT_BITS'(INDEX_BITS);
                state_next = S_ESQ;
            end
            S_ESQ:
            begin
                acc_next   = '0;
                ma_next    = r_reg;
                mb_next    = r_reg;
                ret_next   = S_EDBL;
                state_next = S_MM;
            end
            S_EDBL:
            begin
                if (idx_reg[INDEX_BITS-1])
                begin
                    r_next = add_mod(r_reg, r_reg, mod_reg);
                end
                idx_next = idx_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    e_next = idx_reg[INDEX_BITS-1] ? add_mod(r_reg, r_reg, mod_reg) : r_reg;
                    state_next = S_XINIT;
                end
                else
                begin
                    state_next = S_ESQ;
                end
            end
            S_XINIT:
            begin
                if (n_reg == '0)
                begin
                    r_next     = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mod_next   = n_reg;
                    base_next  = seed_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_BITS'(SEED_BITS);
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                // restoring reduction of the seed, one bit a cycle
                if (red_trial >= {1'b0, mod_reg})
                begin
                    rem_next = red_trial - {1'b0, mod_reg};
                end
                else
                begin
                    rem_next = red_trial;
                end
                base_next = base_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    base_next  = rem_next[SEED_BITS-1:0];
                    r_next     = (mod_reg == ONE) ? '0 : ONE;
                    cnt_next   = CNT_BITS'(SEED_BITS);
                    state_next = S_XSQ;
                end
            end
            S_XSQ:
            begin
                acc_next   = '0;
                ma_next    = r_reg;
                mb_next    = r_reg;
                ret_next   = S_XBIT;
                state_next = S_MM;
            end
            S_XBIT:
            begin
                if (e_reg[SEED_BITS-1])
                begin
                    acc_next   = '0;
                    ma_next    = base_reg;
                    mb_next    = r_reg;
                    ret_next   = S_XNEXT;
                    state_next = S_MM;
                end
                else
                begin
                    state_next = S_XNEXT;
                end
            end
            S_XNEXT:
            begin
                e_next   = e_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_XSQ;
                end
            end
            S_MM:
            begin
                // shift-and-add product: add multiplicand on a set bit, double it
                if (mb_reg == '0)
                begin
                    r_next     = acc_reg;
                    state_next = ret_reg;
                end
                else
                begin
                    if (mb_reg[0])
                    begin
                        acc_next = add_mod(acc_reg, ma_reg, mod_reg);
                    end
                    ma_next = add_mod(ma_reg, ma_reg, mod_reg);
                    mb_next = mb_reg >> 1;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = r_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= word_t'(3);
            p_reg         <= PRIME_BITS'(3);
            q_reg         <= PRIME_BITS'(7);
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_SEED)
                begin
                    seed_reg <= cfg_data;
                end
                else if (cfg_index == CFG_FIRST)
                begin
                    p_reg <= cfg_data[PRIME_BITS-1:0];
                end
                else if (cfg_index == CFG_SECOND)
                begin
                    q_reg <= cfg_data[PRIME_BITS-1:0];
                end
            end
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        g_reg    <= g_next;
        dq_reg   <= dq_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        n_reg    <= n_next;
        mod_reg  <= mod_next;
        r_reg    <= r_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

@@ sim/bbs_checker.sv @@
// Checker for the indexed Blum Blum Shub generator: watches the cfg, in and out
// channels, predicts each result and compares it. Depends on bbs_pkg.
`timescale 1ns / 1ps

module bbs_checker
    import bbs_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_valid,
    input  wire                    cfg_ready,
    input  wire [CFG_IDX_BITS-1:0] cfg_index,
    input  wire [SEED_BITS-1:0]    cfg_data,
    input  wire                    in_valid,
    input  wire                    in_ready,
    input  wire [INDEX_BITS-1:0]   seq_index,
    input  wire                    out_valid,
    input  wire                    out_ready,
    input  wire                    random_bit,
    input  wire [SEED_BITS-1:0]    state_value,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic                 bit_lsb;
        logic [SEED_BITS-1:0] value;
    } bbs_result_t;

    logic [SEED_BITS-1:0]  seed_reg;
    logic [PRIME_BITS-1:0] p_reg;
    logic [PRIME_BITS-1:0] q_reg;
    bbs_result_t           expected_q[$];

    // exact (a*b) mod m with 128-bit intermediates
    function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a % m} * {64'd0, b % m};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] powmod(input logic [63:0] base, input logic [63:0] e,
                                           input logic [63:0] m);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] k;
        if (m == 0)
        begin
            return 0;
        end
        r = 1 % m;
        b = base % m;
        k = e;
        while (k != 0)
        begin
            if (k[0])
            begin
                r = mulmod(r, b, m);
            end
            b = mulmod(b, b, m);
            k = k >> 1;
        end
        return r;
    endfunction

    function automatic bbs_result_t predict_state(input logic [INDEX_BITS-1:0] idx);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        logic [63:0] lam;
        logic [63:0] e;
        logic [63:0] x;
        bbs_result_t res;
        p = 64'(p_reg);
        q = 64'(q_reg);
        lam = 0;
        e = 0;
        if (p >= 2 && q >= 2)
        begin
            a = p - 1;
            b = q - 1;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            lam = ((p - 1) / a) * (q - 1);
        end
        if (lam != 0)
        begin
            e = powmod(2, 64'(idx), lam);
        end
        x = powmod(64'(seed_reg), e, p * q);
        res.value = x[SEED_BITS-1:0];
        res.bit_lsb = x[0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bbs_result_t want;
        int          errs;
        if (!rst_n)
        begin
            seed_reg <= 3;
            p_reg <= 3;
            q_reg <= 7;
            expected_q.delete();
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SEED:   seed_reg <= cfg_data;
                    CFG_FIRST:  p_reg <= cfg_data[PRIME_BITS-1:0];
                    CFG_SECOND: q_reg <= cfg_data[PRIME_BITS-1:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_q = {expected_q, predict_state(seq_index)};
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result beat: state_value %0d", state_value);
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.value !== state_value)
                    begin
                        $error("state_value: expected %0d, actual %0d", want.value,
                               state_value);
                        errs++;
                    end
                    if (want.bit_lsb !== random_bit)
                    begin
                        $error("random_bit: expected %0d, actual %0d", want.bit_lsb,
                               random_bit);
                        errs++;
                    end
                end
            end
            if (errs != 0)
            begin
                fail_count <= fail_count + errs;
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

@@ sim/blum_blum_shub_indexed_bit_top_tb.sv @@
// Testbench top for the indexed Blum Blum Shub generator: clock, reset, config
// phases and random stimulus. Depends on bbs_pkg, the block and bbs_checker.
`timescale 1ns / 1ps

module blum_blum_shub_indexed_bit_top_tb;
    import bbs_pkg::*;

    localparam int MAX_CYCLES = 20_000_000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SEED_BITS-1:0]    cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [INDEX_BITS-1:0]   seq_index;
    logic                    out_valid;
    logic                    out_ready;
    logic                    random_bit;
    logic [SEED_BITS-1:0]    state_value;
    int                      fail_count;
    int                      pending_count;
    int                      cycle_count;
    bit                      hold_sink;

    blum_blum_shub_indexed_bit_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .seq_index(seq_index),
        .out_valid(out_valid), .out_ready(out_ready), .random_bit(random_bit),
        .state_value(state_value)
    );

    bbs_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .seq_index(seq_index),
        .out_valid(out_valid), .out_ready(out_ready), .random_bit(random_bit),
        .state_value(state_value),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES)
            begin
                $display("blum_blum_shub_indexed_bit_top regression: fail");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 150);
    endfunction

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                repeat (12000) @(negedge clk);
                hold_sink = 1'b0;
            end
            g = gap_len();
            if (g == 0)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [SEED_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_index(input logic [INDEX_BITS-1:0] idx, input int gaps);
        int g;
        g = (gaps != 0) ? gap_len() : 0;
        @(negedge clk);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        seq_index <= idx;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (50) @(negedge clk);
    endtask

    task automatic set_config(input logic [SEED_BITS-1:0] seed,
                              input logic [PRIME_BITS-1:0] p,
                              input logic [PRIME_BITS-1:0] q);
        drain();
        write_reg(CFG_SEED, seed);
        write_reg(CFG_FIRST, {{(SEED_BITS-PRIME_BITS){1'b0}}, p});
        write_reg(CFG_SECOND, {{(SEED_BITS-PRIME_BITS){1'b0}}, q});
    endtask

    function automatic logic [PRIME_BITS-1:0] pick_prime();
        logic [PRIME_BITS-1:0] list [8] = '{3, 7, 11, 19, 23, 131071, 65519, 1019};
        return list[$urandom_range(0, 7)];
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_index();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [SEED_BITS-1:0] s;
        rst_n = 1'b0;
        hold_sink = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SEED;
        cfg_data = '0;
        in_valid = 1'b0;
        seq_index = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, index extremes
        send_index(0, 0);
        send_index(1, 0);
        send_index(2, 0);
        send_index(32'hFFFF_FFFF, 0);
        send_index(32'hAAAA_AAAA, 0);
        send_index(32'h5555_5555, 0);
        // largest primes and seed at all ones (not below n)
        set_config({SEED_BITS{1'b1}}, 17'h1FFFF, 17'h1FFFF);
        send_index(32'hFFFF_FFFF, 0);
        send_index(7, 0);
        set_config(34'd17179607040, 131071, 65519);
        send_index(32'h8000_0000, 0);
        // prime below two
        set_config(5, 1, 7);
        send_index(9, 0);
        set_config(5, 0, 0);
        send_index(9, 0);
        // lambda of one: p = q = 2
        set_config(3, 2, 2);
        send_index(4, 0);
        // modulus one
        set_config(12345, 1, 1);
        send_index(3, 0);
        // seed zero, seed one
        set_config(0, 11, 19);
        send_index(5, 0);
        set_config(1, 11, 19);
        send_index(5, 0);
        set_config(34'h2_AAAA_AAAA, 17'h15555, 17'h0AAAA);
        send_index(33, 0);

        // fill the block while the receiver is held off
        hold_sink = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            send_index(pick_index(), 0);
        end

        for (int phase = 0; phase < 7; phase++)
        begin
            s = SEED_BITS'({$urandom(), $urandom()});
            if ($urandom_range(0, 3) != 0)
            begin
                s = SEED_BITS'(64'(s) % (64'(pick_prime()) * 64'(pick_prime()) + 64'd1));
            end
            set_config(s, pick_prime(), pick_prime());
            for (int k = 0; k < 100; k++)
            begin
                send_index(pick_index(), 1);
            end
        end
        // fully random p and q, which may be even, odd or not prime
        set_config(SEED_BITS'({$urandom(), $urandom()}), 17'($urandom()), 17'($urandom()));
        for (int k = 0; k < 10; k++)
        begin
            send_index(pick_index(), 1);
        end

        drain();
        if (fail_count == 0)
        begin
            $display("blum_blum_shub_indexed_bit_top regression: pass");
        end
        else
        begin
            $display("blum_blum_shub_indexed_bit_top regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bbs_pkg.sv
hw/rtl/blum_blum_shub_indexed_bit_top.sv
sim/bbs_checker.sv
sim/blum_blum_shub_indexed_bit_top_tb.sv
